@@ hw/rtl/tpc_pkg.sv @@
// Shared types, constants and helpers for the temperature and pressure compensation pipeline.
// Used by tpc_div and temp_pressure_compensation_unit; no dependencies.
package tpc_pkg;

    localparam int unsigned DivW = 32;

    localparam logic [1:0] CfgTempCoeffs = 2'd0;
    localparam logic [1:0] CfgPresCoeffsA = 2'd1;
    localparam logic [1:0] CfgPresCoeffsB = 2'd2;

    localparam logic signed [63:0] PresTempOffset = 64'sd64000;
    localparam logic signed [63:0] PresBase = 64'sd1048576;
    localparam logic signed [24:0] DivOffset = 25'sd32768;
    localparam logic [31:0] PresScale = 32'd3125;
    localparam logic [31:0] HalfRange = 32'h4000_0000;

    typedef struct packed {
        logic [31:0] tfine;
        logic [31:0] tcent;
        logic        big;
        logic        invalid;
    } t_side;

    // Signed division by 2**k, truncating toward zero.
    function automatic logic signed [63:0] sdiv2k(input logic signed [63:0] x,
                                                  input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

@@ hw/rtl/tpc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband struct.
// Depends on tpc_pkg.
module tpc_div
    import tpc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [DivW-1:0] i_dividend,
    input  logic [DivW-1:0] i_divisor,
    input  t_side           i_side,
    output logic            o_valid,
    output logic [DivW-1:0] o_quot,
    output t_side           o_side
);

    logic [DivW-1:0] r_rem [DivW];
    logic [DivW-1:0] r_dvd [DivW];
    logic [DivW-1:0] r_quo [DivW];
    logic [DivW-1:0] r_dsr [DivW];
    t_side           r_side [DivW];
    logic [DivW-1:0] r_vld;

    for (genvar g = 0; g < DivW; g++) begin : g_stage
        logic [DivW-1:0] p_rem, p_dvd, p_quo, p_dsr;
        t_side           p_side;
        logic [DivW:0]   trial;
        logic [DivW:0]   diff;
        logic            ge;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_dvd  = i_dividend;
            assign p_quo  = '0;
            assign p_dsr  = i_divisor;
            assign p_side = i_side;
        end else begin : g_rest
            assign p_rem  = r_rem[g-1];
            assign p_dvd  = r_dvd[g-1];
            assign p_quo  = r_quo[g-1];
            assign p_dsr  = r_dsr[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            trial = {p_rem, p_dvd[DivW-1]};
            diff  = trial - {1'b0, p_dsr};
            ge    = (trial >= {1'b0, p_dsr});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
                r_dvd[g]  <= {p_dvd[DivW-2:0], 1'b0};
                r_quo[g]  <= {p_quo[DivW-2:0], ge};
                r_dsr[g]  <= p_dsr;
                r_side[g] <= p_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivW-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[DivW-1];
    assign o_quot  = r_quo[DivW-1];
    assign o_side  = r_side[DivW-1];

endmodule

@@ hw/rtl/temp_pressure_compensation_unit.sv @@
// Top level of the temperature and pressure compensation pipeline.
// Depends on tpc_pkg and tpc_div.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready        | i_raw_temperature, i_raw_pressure
//  out      | o_out_valid / i_out_ready      | o_fine_temperature, o_temperature_centi,
//           |                                | o_pressure_pa, o_pressure_invalid
//  cfg      | i_cfg_we (no wait)             | i_cfg_index, i_cfg_data
//
// One request per cycle unless the output stalls; 10 polynomial stages, 32 divider stages
// (one quotient bit each) and 7 output polynomial stages.
// Synchronous active-low reset clears the valid bits and the coefficient registers.
// A stalled result at the output holds the whole pipeline; nothing is dropped or repeated.
module temp_pressure_compensation_unit
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_fine_temperature,
    output logic signed [31:0] o_temperature_centi,
    output logic signed [31:0] o_pressure_pa,
    output logic        o_pressure_invalid,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [39:0] r_temp_c;
    logic [63:0] r_pres_a;
    logic [63:0] r_pres_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_c <= '0;
            r_pres_a <= '0;
            r_pres_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgTempCoeffs:  r_temp_c <= i_cfg_data[39:0];
                CfgPresCoeffsA: r_pres_a <= i_cfg_data;
                CfgPresCoeffsB: r_pres_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        [15:0] c_t1, c_p1;
    logic signed [15:0] c_t2, c_p2, c_p4, c_p5, c_p8, c_p9;
    logic signed [7:0]  c_t3, c_p3, c_p6, c_p7, c_p10;

    assign c_t1  = r_temp_c[15:0];
    assign c_t2  = $signed(r_temp_c[31:16]);
    assign c_t3  = $signed(r_temp_c[39:32]);
    assign c_p1  = r_pres_a[15:0];
    assign c_p2  = $signed(r_pres_a[31:16]);
    assign c_p4  = $signed(r_pres_a[47:32]);
    assign c_p5  = $signed(r_pres_a[63:48]);
    assign c_p8  = $signed(r_pres_b[15:0]);
    assign c_p9  = $signed(r_pres_b[31:16]);
    assign c_p3  = $signed(r_pres_b[39:32]);
    assign c_p6  = $signed(r_pres_b[47:40]);
    assign c_p7  = $signed(r_pres_b[55:48]);
    assign c_p10 = $signed(r_pres_b[63:56]);

    logic       en;
    logic [9:0] r_pv;
    logic [6:0] r_qv;
    logic       div_vld;

    assign en          = !r_qv[6] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_qv[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_qv <= '0;
        end else if (en) begin
            r_pv <= {r_pv[8:0], i_in_valid};
            r_qv <= {r_qv[5:0], div_vld};
        end
    end

    // temperature
    logic signed [17:0] n1_at, r1_at;
    logic        [19:0] r1_rp, r2_rp, r3_rp, r4_rp, r5_rp, r6_rp, r7_rp, r8_rp;
    logic signed [16:0] n2_ah;
    logic signed [33:0] n2_tb, r2_tb, n2_sq;
    logic        [31:0] r2_tsq;
    logic signed [23:0] r3_tb;
    logic signed [11:0] n3_t3x;
    logic signed [32:0] n3_tc, r3_tc;
    logic signed [31:0] n4_tf, r4_tf;
    logic signed [31:0] n5_x, r5_tf, r5_tc;
    logic signed [23:0] r5_pa;

    assign n1_at  = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, c_t1, 1'b0});
    assign n2_tb  = r1_at * c_t2;
    assign n2_ah  = 17'(sdiv2k(r1_at, 1));
    assign n2_sq  = n2_ah * n2_ah;
    assign n3_t3x = c_t3 * 12'sd16;
    assign n3_tc  = $signed({1'b0, r2_tsq[31:12]}) * n3_t3x;
    assign n4_tf  = r3_tb + 32'(sdiv2k(r3_tc, 14));
    assign n5_x   = r4_tf * 32'sd5 + 32'sd128;

    // pressure divisor and offset
    logic signed [21:0] n6_pq;
    logic signed [43:0] n6_sq;
    logic        [37:0] r6_sq;
    logic signed [39:0] n6_ap5, r6_ap5, n6_ap2, r6_ap2, r7_ap5, r7_ap2;
    logic signed [12:0] n7_p3x;
    logic signed [35:0] n7_b1, r7_b1;
    logic signed [38:0] n7_a1, r7_a1;
    logic signed [63:0] n8_bt, n8_b, n8_a2, r8_b;
    logic signed [23:0] r8_a3;
    logic signed [24:0] n9_ao;
    logic signed [41:0] n9_m, r9_m;
    logic signed [63:0] n9_x;
    logic        [31:0] r9_x;
    logic        [31:0] n10_div, n10_num, n10_dvd;
    logic        [31:0] r10_div, r10_dvd;
    t_side              r6_sd, r7_sd, r8_sd, r9_sd, r10_sd, n10_sd;

    assign n6_pq  = 22'(sdiv2k(r5_pa, 2));
    assign n6_sq  = n6_pq * n6_pq;
    assign n6_ap5 = r5_pa * c_p5;
    assign n6_ap2 = r5_pa * c_p2;
    assign n7_b1  = $signed({1'b0, r6_sq[37:11]}) * c_p6;
    assign n7_p3x = c_p3 * 13'sd32;
    assign n7_a1  = $signed({1'b0, r6_sq[37:13]}) * n7_p3x;
    assign n8_bt  = sdiv2k(r7_b1, 2) + (64'(r7_ap5) <<< 1);
    assign n8_b   = sdiv2k(n8_bt, 2) + (64'(c_p4) <<< 16);
    assign n8_a2  = sdiv2k(r7_a1, 3) + sdiv2k(r7_ap2, 1);
    assign n9_ao  = r8_a3 + DivOffset;
    assign n9_m   = n9_ao * $signed({1'b0, c_p1});
    assign n9_x   = PresBase - $signed({44'b0, r8_rp}) - sdiv2k(r8_b, 12);
    assign n10_div = 32'(sdiv2k(r9_m, 15));
    assign n10_num = r9_x * PresScale;
    assign n10_dvd = (n10_num >= HalfRange) ? n10_num : {n10_num[30:0], 1'b0};

    always_comb begin
        n10_sd         = r9_sd;
        n10_sd.big     = (n10_num >= HalfRange);
        n10_sd.invalid = (n10_div == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_at  <= n1_at;
            r1_rp  <= i_raw_pressure;
            r2_tb  <= n2_tb;
            r2_tsq <= n2_sq[31:0];
            r2_rp  <= r1_rp;
            r3_tb  <= 24'(sdiv2k(r2_tb, 11));
            r3_tc  <= n3_tc;
            r3_rp  <= r2_rp;
            r4_tf  <= n4_tf;
            r4_rp  <= r3_rp;
            r5_tf  <= r4_tf;
            r5_tc  <= 32'(sdiv2k(n5_x, 8));
            r5_pa  <= 24'(sdiv2k(r4_tf, 1) - PresTempOffset);
            r5_rp  <= r4_rp;
            r6_sq  <= n6_sq[37:0];
            r6_ap5 <= n6_ap5;
            r6_ap2 <= n6_ap2;
            r6_rp  <= r5_rp;
            r6_sd  <= '{tfine: r5_tf, tcent: r5_tc, big: 1'b0, invalid: 1'b0};
            r7_b1  <= n7_b1;
            r7_a1  <= n7_a1;
            r7_ap5 <= r6_ap5;
            r7_ap2 <= r6_ap2;
            r7_rp  <= r6_rp;
            r7_sd  <= r6_sd;
            r8_b   <= n8_b;
            r8_a3  <= 24'(sdiv2k(n8_a2, 18));
            r8_rp  <= r7_rp;
            r8_sd  <= r7_sd;
            r9_m   <= n9_m;
            r9_x   <= n9_x[31:0];
            r9_sd  <= r8_sd;
            r10_div <= n10_div;
            r10_dvd <= n10_dvd;
            r10_sd  <= n10_sd;
        end
    end

    logic [31:0] div_quot;
    t_side       div_side;

    tpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_pv[9]),
        .i_dividend (r10_dvd),
        .i_divisor  (r10_div),
        .i_side     (r10_sd),
        .o_valid    (div_vld),
        .o_quot     (div_quot),
        .o_side     (div_side)
    );

    // pressure polynomial on the quotient
    logic        [31:0] r_q1, r_q2, r_q3, r_q4, r_q5, r_q6;
    t_side              r_sd1, r_sd2, r_sd3, r_sd4, r_sd5, r_sd6;
    logic        [57:0] r_qsq;
    logic signed [46:0] n_qb, r_qb;
    logic        [47:0] r_cs;
    logic signed [61:0] n_am, r_am;
    logic signed [63:0] r_bq3, r_bq4, r_bq5, r_a4, r_a5, r_sum;
    logic        [47:0] r_lo, r_hi;
    logic        [63:0] r_cube;
    logic signed [71:0] n_cp;
    logic        [63:0] r_cp;
    logic signed [63:0] n_sum, n_pres;

    assign n_qb   = $signed({1'b0, r_q1[31:2]}) * c_p8;
    assign n_am   = $signed({1'b0, r_qsq[57:13]}) * c_p9;
    assign n_cp   = $signed(r_cube) * c_p10;
    assign n_sum  = r_a5 + r_bq5 + sdiv2k($signed(r_cp), 17) + (64'(c_p7) <<< 7);
    assign n_pres = $signed({32'b0, r_q6}) + sdiv2k(r_sum, 4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1   <= div_side.big ? {div_quot[30:0], 1'b0} : div_quot;
            r_sd1  <= div_side;
            r_qsq  <= r_q1[31:3] * r_q1[31:3];
            r_qb   <= n_qb;
            r_cs   <= r_q1[31:8] * r_q1[31:8];
            r_q2   <= r_q1;
            r_sd2  <= r_sd1;
            r_am   <= n_am;
            r_bq3  <= sdiv2k(r_qb, 13);
            r_lo   <= r_cs[23:0] * r_q2[31:8];
            r_hi   <= r_cs[47:24] * r_q2[31:8];
            r_q3   <= r_q2;
            r_sd3  <= r_sd2;
            r_a4   <= sdiv2k(r_am, 12);
            r_bq4  <= r_bq3;
            r_cube <= {16'b0, r_lo} + ({16'b0, r_hi} << 24);
            r_q4   <= r_q3;
            r_sd4  <= r_sd3;
            r_cp   <= n_cp[63:0];
            r_a5   <= r_a4;
            r_bq5  <= r_bq4;
            r_q5   <= r_q4;
            r_sd5  <= r_sd4;
            r_sum  <= n_sum;
            r_q6   <= r_q5;
            r_sd6  <= r_sd5;
            o_fine_temperature  <= r_sd6.tfine;
            o_temperature_centi <= r_sd6.tcent;
            o_pressure_invalid  <= r_sd6.invalid;
            o_pressure_pa       <= r_sd6.invalid ? 32'sd0 : n_pres[31:0];
        end
    end

endmodule

@@ bench/tb_temp_pressure_compensation_unit.sv @@
// Testbench for temp_pressure_compensation_unit: random and directed readings under
// valid/ready back pressure, results checked in order against an in-bench predictor.
// Depends on tpc_pkg and the compensation unit RTL.
`timescale 1ns / 1ps

module tb_temp_pressure_compensation_unit
    import tpc_pkg::*;
();

    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int CycleLimit = 600000;
    localparam int DrainCycles = 60;

    typedef struct {
        logic [31:0] tfine;
        logic [31:0] tcent;
        logic [31:0] pres;
        logic        invalid;
    } t_reading;

    class compensation_scoreboard;
        logic [39:0] temp_cf;
        logic [63:0] pres_cf_a;
        logic [63:0] pres_cf_b;
        t_reading    pending[$];
        int          mismatches;

        function void set_coeffs(logic [1:0] idx, logic [63:0] val);
            if (idx == CfgTempCoeffs) temp_cf = val[39:0];
            else if (idx == CfgPresCoeffsA) pres_cf_a = val;
            else if (idx == CfgPresCoeffsB) pres_cf_b = val;
        endfunction

        function void note_request(logic [19:0] raw_t, logic [19:0] raw_p);
            longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
            longint a, b, c, q, tfine, cube, sum;
            logic [31:0] w, num, dv, res;
            t_reading r;
            rt = longint'(raw_t);
            rp = longint'(raw_p);
            t1 = longint'(temp_cf[15:0]);
            t2 = longint'($signed(temp_cf[31:16]));
            t3 = longint'($signed(temp_cf[39:32]));
            p1 = longint'(pres_cf_a[15:0]);
            p2 = longint'($signed(pres_cf_a[31:16]));
            p4 = longint'($signed(pres_cf_a[47:32]));
            p5 = longint'($signed(pres_cf_a[63:48]));
            p8 = longint'($signed(pres_cf_b[15:0]));
            p9 = longint'($signed(pres_cf_b[31:16]));
            p3 = longint'($signed(pres_cf_b[39:32]));
            p6 = longint'($signed(pres_cf_b[47:40]));
            p7 = longint'($signed(pres_cf_b[55:48]));
            p10 = longint'($signed(pres_cf_b[63:56]));

            a = rt / 8 - t1 * 2;
            b = (a * t2) / 2048;
            c = ((a / 2) * (a / 2)) / 4096;
            c = (c * (t3 * 16)) / 16384;
            sum = b + c;
            tfine = longint'($signed(sum[31:0]));
            w = 32'(tfine * 5 + 128);
            r.tfine = tfine[31:0];
            q = longint'($signed(w)) / 256;
            r.tcent = q[31:0];

            a = tfine / 2 - 64000;
            b = ((((a / 4) * (a / 4)) / 2048) * p6) / 4;
            b = b + (a * p5) * 2;
            b = b / 4 + p4 * 65536;
            a = (((((a / 4) * (a / 4)) / 8192) * (p3 * 32)) / 8) + (p2 * a) / 2;
            a = a / 262144;
            a = ((32768 + a) * p1) / 32768;
            dv = a[31:0];
            r.invalid = (dv == 32'd0);
            r.pres = 32'd0;
            if (!r.invalid) begin
                sum = ((1048576 - rp) - b / 4096) * 3125;
                num = sum[31:0];
                if (num >= HalfRange) res = (num / dv) * 32'd2;
                else res = (num * 32'd2) / dv;
                q = longint'(res);
                a = (p9 * (((q / 8) * (q / 8)) / 8192)) / 4096;
                b = ((q / 4) * p8) / 8192;
                cube = (q / 256) * (q / 256) * (q / 256);
                cube = cube * p10;
                c = cube / 131072;
                sum = q + (a + b + c + p7 * 128) / 16;
                r.pres = sum[31:0];
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] tf, logic [31:0] tc, logic [31:0] pr,
                                   logic inv);
            t_reading e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result tfine=%0d", $signed(tf));
                return;
            end
            e = pending.pop_front();
            if (tf !== e.tfine || tc !== e.tcent || pr !== e.pres || inv !== e.invalid) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                             $signed(e.tfine), $signed(e.tcent), $signed(e.pres), e.invalid,
                             $signed(tf), $signed(tc), $signed(pr), inv);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] fine_t;
    logic signed [31:0] temp_c;
    logic signed [31:0] pres_pa;
    logic        pres_inv;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    compensation_scoreboard sb;
    int send_idle;
    int recv_idle;
    int hold_cycles;
    int cycle_count;

    temp_pressure_compensation_unit dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_raw_temperature(raw_t),
        .i_raw_pressure(raw_p),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_fine_temperature(fine_t),
        .o_temperature_centi(temp_c),
        .o_pressure_pa(pres_pa),
        .o_pressure_invalid(pres_inv),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(fine_t, temp_c, pres_pa, pres_inv);
    end

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready = 1'b0;
        end else begin
            out_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_request(logic [19:0] t, logic [19:0] p);
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        raw_t = t;
        raw_p = p;
        do @(posedge clk); while (!in_ready);
        sb.note_request(t, p);
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_coeffs(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // typical calibration set, optionally perturbed
    task automatic load_typical(bit jitter);
        logic [15:0] t1, t2, p1, p2, p4, p5, p8, p9;
        logic [7:0]  t3, p3, p6, p7, p10;
        t1 = 16'd26000 + 16'(jitter ? $urandom_range(3000) : 0);
        t2 = 16'd26000 - 16'(jitter ? $urandom_range(3000) : 0);
        t3 = jitter ? 8'($urandom_range(5)) : 8'd3;
        p1 = 16'd36000 + 16'(jitter ? $urandom_range(2000) : 0);
        p2 = -16'sd10300;
        p3 = 8'd88;
        p4 = 16'd7000 + 16'(jitter ? $urandom_range(500) : 0);
        p5 = -16'sd150;
        p6 = 8'd30;
        p7 = 8'd40;
        p8 = -16'sd3000;
        p9 = -16'sd2500;
        p10 = jitter ? 8'($urandom_range(255)) : 8'd30;
        write_reg(CfgTempCoeffs, {24'h0, t3, t2, t1});
        write_reg(CfgPresCoeffsA, {p5, p4, p2, p1});
        write_reg(CfgPresCoeffsB, {p10, p7, p6, p3, p9, p8});
    endtask

    task automatic load_random();
        write_reg(CfgTempCoeffs, {$urandom, $urandom});
        write_reg(CfgPresCoeffsA, {$urandom, $urandom});
        write_reg(CfgPresCoeffsB, {$urandom, $urandom});
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) != 0)
                send_request(20'd400000 + 20'($urandom_range(200000)),
                             20'd250000 + 20'($urandom_range(300000)));
            else
                send_request(20'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.temp_cf = '0;
        sb.pres_cf_a = '0;
        sb.pres_cf_b = '0;
        sb.mismatches = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_t = '0;
        raw_p = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // all-zero coefficients: divisor zero
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        drain_pipe();
        load_typical(1'b0);
        write_reg(CfgUnused, {64{1'b1}});
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'd512000, 20'd0);
        send_request(20'd512000, 20'hFFFFF);
        send_request(20'd480000, 20'd300000);
        send_request(20'd0, 20'hFFFFF);
        drain_pipe();
        write_reg(CfgTempCoeffs, {64{1'b1}});
        write_reg(CfgPresCoeffsA, {64{1'b1}});
        write_reg(CfgPresCoeffsB, {64{1'b1}});
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'hFFFFF, 20'd0);
        drain_pipe();
        write_reg(CfgTempCoeffs, 64'h80_8000_0000);
        write_reg(CfgPresCoeffsA, 64'h8000_8000_8000_FFFF);
        write_reg(CfgPresCoeffsB, 64'h7F80_7F80_7FFF_8000);
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'h80000, 20'h7FFFF);
        drain_pipe();

        send_idle = 15;
        recv_idle = 76;
        load_typical(1'b1);
        random_phase(350);
        drain_pipe();
        load_random();
        random_phase(300);
        drain_pipe();

        send_idle = 76;
        recv_idle = 15;
        load_typical(1'b1);
        random_phase(350);
        drain_pipe();
        load_random();
        random_phase(300);
        drain_pipe();

        send_idle = 0;
        recv_idle = 0;
        load_typical(1'b1);
        hold_cycles = 300;
        random_phase(350);
        drain_pipe();
        load_random();
        random_phase(350);
        drain_pipe();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
